@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helper macros used by acw_back.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge outside reset.
`define ACW_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition seen on one edge implies another condition on the next edge.
`define ACW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/acw_pkg.sv @@
// ----------------------------------------------------------------------------
// acw_pkg
// Types and constants shared by the angular collimator weight core.
// ----------------------------------------------------------------------------
package acw_pkg;

    localparam int ZW = 48;
    localparam int ZFRAC = 24;
    localparam int PRE_SHIFT = 20;
    localparam int TAB_LEN = 25;

    typedef enum logic [1:0] {
        ST_PASS   = 2'd0,
        ST_ABSORB = 2'd1,
        ST_MARKER = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        REG_MODE  = 3'd0,
        REG_COUNT = 3'd1,
        REG_PEAK  = 3'd2,
        REG_HW    = 3'd3,
        REG_SPACE = 3'd4,
        REG_FIRST = 3'd5
    } reg_idx_t;

    // Item queued between front and back.
    typedef struct packed {
        logic        marker;
        logic [31:0] weight;
        logic [35:0] angle;
    } item_t;

    typedef enum logic [2:0] {
        BK_IDLE, BK_WALK, BK_DIV, BK_MUL, BK_OUT
    } back_state_t;

    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic signed [ZW-1:0] r;
        case (i)
            0: r = 48'sd754974720;  1: r = 48'sd445687602;
            2: r = 48'sd235489088;  3: r = 48'sd119537938;
            4: r = 48'sd60000934;   5: r = 48'sd30029717;
            6: r = 48'sd15018523;   7: r = 48'sd7509720;
            8: r = 48'sd3754917;    9: r = 48'sd1877466;
            10: r = 48'sd938734;    11: r = 48'sd469367;
            12: r = 48'sd234684;    13: r = 48'sd117342;
            14: r = 48'sd58671;     15: r = 48'sd29335;
            16: r = 48'sd14668;     17: r = 48'sd7334;
            18: r = 48'sd3667;      19: r = 48'sd1833;
            20: r = 48'sd917;       21: r = 48'sd458;
            22: r = 48'sd229;       23: r = 48'sd115;
            24: r = 48'sd57;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ sv/acw_front.sv @@
// ----------------------------------------------------------------------------
// acw_front
// Accept trajectories and compute the divergence angle by CORDIC vectoring.
// ----------------------------------------------------------------------------
module acw_front #(
    parameter int CORDIC_STEPS = 16,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [17:0]  vel_x,
    input  logic signed [17:0]  vel_y,
    input  logic [31:0]         weight,
    input  logic                end_marker,
    output logic                q_valid,
    input  logic                q_ready,
    output acw_pkg::item_t      q_item
);
    import acw_pkg::*;

    localparam int STEPS = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
    localparam int SW = $clog2(STEPS + 1);
    localparam int SH = ZFRAC - ANGLE_FRAC_BITS;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [SW-1:0]        step_reg, step_next;
    logic signed [ZW-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [31:0]          w_reg, w_next;
    logic                 mk_reg, mk_next;
    logic signed [ZW-1:0] xs, ys, vx, vy, zr;

    assign in_ready = !busy_reg && !done_reg;
    assign vx = ZW'(vel_x) <<< PRE_SHIFT;
    assign vy = ZW'(vel_y) <<< PRE_SHIFT;
    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;
    assign zr = (z_reg + (ZW'(1) <<< (SH - 1))) >>> SH;

    always_comb begin
        busy_next = busy_reg; done_next = done_reg; step_next = step_reg;
        x_next = x_reg; y_next = y_reg; z_next = z_reg;
        w_next = w_reg; mk_next = mk_reg;
        if (in_valid && in_ready) begin
            w_next = weight; mk_next = end_marker; step_next = '0; z_next = '0;
            x_next = vx; y_next = vy;
            if (end_marker || vel_y == 0) begin
                done_next = 1'b1;
                z_next = (vel_x < 0) ? (ZW'(180) <<< ZFRAC) : '0;
            end else begin
                busy_next = 1'b1;
                if (vel_x < 0) begin
                    x_next = -vx; y_next = -vy;
                    z_next = (vel_y >= 0) ? (ZW'(180) <<< ZFRAC) : -(ZW'(180) <<< ZFRAC);
                end
            end
        end else if (busy_reg) begin
            if (y_reg > 0) begin
                x_next = x_reg + ys; y_next = y_reg - xs;
                z_next = z_reg + atan_entry(int'(step_reg));
            end else begin
                x_next = x_reg - ys; y_next = y_reg + xs;
                z_next = z_reg - atan_entry(int'(step_reg));
            end
            step_next = step_reg + 1'b1;
            if (int'(step_reg) == STEPS - 1) begin
                busy_next = 1'b0; done_next = 1'b1;
            end
        end else if (done_reg && q_ready) begin
            done_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0; step_reg <= '0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next; step_reg <= step_next;
        end
        x_reg <= x_next; y_reg <= y_next; z_reg <= z_next;
        w_reg <= w_next; mk_reg <= mk_next;
    end

    assign q_valid = done_reg;
    assign q_item.marker = mk_reg;
    assign q_item.weight = w_reg;
    assign q_item.angle = zr[35:0];
endmodule

@@ sv/acw_queue.sv @@
// ----------------------------------------------------------------------------
// acw_queue
// Two-entry queue between the angle front and the weight back end.
// ----------------------------------------------------------------------------
module acw_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  acw_pkg::item_t wr_item,
    output logic           rd_valid,
    input  logic           rd_ready,
    output acw_pkg::item_t rd_item
);
    import acw_pkg::*;

    item_t       mem_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic        wr, rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_item = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
        if (wr) mem_reg[wp_reg] <= wr_item;
    end
endmodule

@@ sv/acw_back.sv @@
// ----------------------------------------------------------------------------
// acw_back
// Walk the collimation centres, divide and scale the weight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module acw_back #(
    parameter int MAX_CENTERS = 64
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  acw_pkg::item_t q_item,
    input  logic           angular_mode,
    input  logic [6:0]     center_count,
    input  logic [16:0]    peak_transmission,
    input  logic [15:0]    half_width,
    input  logic signed [16:0] center_spacing,
    input  logic signed [16:0] first_center,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [1:0]     out_status,
    output logic [31:0]    out_weight
);
    import acw_pkg::*;

    localparam int CW = 11;

    back_state_t st_reg, st_next;
    logic [CW-1:0]       j_reg, n_reg;
    logic signed [47:0]  c_reg, d, ad;
    logic signed [47:0]  ang_reg;
    logic [31:0]         w_reg;
    logic [33:0]         num_reg;  // partial remainder
    logic [33:0]         quo_reg;
    logic [5:0]          bit_reg;
    logic [49:0]         prod;
    logic [1:0]          stat_reg;
    logic [31:0]         wout_reg;
    logic signed [47:0]  pitch;
    logic [CW-1:0]       nsel;

    assign pitch = 48'(2 * $signed({1'b0, half_width})) + 48'(center_spacing);
    assign d = c_reg - ang_reg;
    assign ad = d[47] ? -d : d;

    always_comb begin
        if (angular_mode && center_count > 7'd1)
            nsel = (int'(center_count) > MAX_CENTERS) ? CW'(MAX_CENTERS) : CW'(center_count);
        else
            nsel = CW'(1);
    end

    assign q_ready = (st_reg == BK_IDLE);
    assign out_valid = (st_reg == BK_OUT);
    assign out_status = stat_reg;
    assign out_weight = wout_reg;
    assign prod = 50'(w_reg) * 50'(quo_reg[17:0]);

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            BK_IDLE: if (q_valid) st_next = q_item.marker ? BK_OUT : BK_WALK;
            BK_WALK: if (ad < 48'($signed({1'b0, half_width}))) st_next = BK_DIV;
                     else if (j_reg == n_reg - 1'b1) st_next = BK_OUT;
            BK_DIV:  if (bit_reg == 6'd0) st_next = BK_MUL;
            BK_MUL:  st_next = BK_OUT;
            BK_OUT:  if (out_ready) st_next = BK_IDLE;
            default: st_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) st_reg <= BK_IDLE;
        else st_reg <= st_next;
        case (st_reg)
            BK_IDLE: begin
                ang_reg <= 48'(signed'(q_item.angle));
                w_reg <= q_item.weight;
                wout_reg <= q_item.weight;
                stat_reg <= q_item.marker ? ST_MARKER : ST_ABSORB;
                j_reg <= '0;
                n_reg <= nsel;
                c_reg <= (angular_mode && center_count > 7'd1) ? 48'(first_center) : '0;
            end
            BK_WALK: begin
                j_reg <= j_reg + 1'b1;
                c_reg <= c_reg + pitch;
                // numerator = peak * (hw - d), 33 bits; divide bit by bit
                num_reg <= '0;
                quo_reg <= 34'(peak_transmission) * 34'(half_width - ad[15:0]);
                bit_reg <= 6'd33;
            end
            BK_DIV: begin
                // restoring division: quo_reg shifts out numerator, in quotient
                if ({num_reg[32:0], quo_reg[33]} >= 34'(half_width)) begin
                    num_reg <= {num_reg[32:0], quo_reg[33]} - 34'(half_width);
                    quo_reg <= {quo_reg[32:0], 1'b1};
                end else begin
                    num_reg <= {num_reg[32:0], quo_reg[33]};
                    quo_reg <= {quo_reg[32:0], 1'b0};
                end
                bit_reg <= bit_reg - 1'b1;
            end
            BK_MUL: begin
                stat_reg <= ST_PASS;
                wout_reg <= (prod[49:16] > 34'hFFFFFFFF) ? 32'hFFFFFFFF : prod[47:16];
            end
            default: ;
        endcase
    end

    `ACW_ASSERT(a_out_status, aclk, aresetn, !out_valid || out_status != 2'd3, "bad status")
    `ACW_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_valid && !out_ready, out_valid, "result lost")
    `ACW_ASSERT(a_walk_bound, aclk, aresetn, st_reg != BK_WALK || j_reg < n_reg, "walk overrun")
endmodule

@@ sv/angular_collimator_weight_core.sv @@
// ----------------------------------------------------------------------------
// angular_collimator_weight_core
// Angular collimator: CORDIC divergence angle, centre walk, weight scaling.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// s_axis    in   tdata = vel_x[17:0], vel_y[35:18], weight[67:36]; tlast = end_marker
// m_axis    out  tdata = weight_out[31:0]; tuser = status[1:0]
// cfg       in   cfg_we, cfg_index (register list order), cfg_wdata
//
// A trajectory runs the CORDIC vectoring loop in the front; end markers and
// zero transverse velocity skip it. The back end takes the item, tries the
// centres in turn until one hits, runs the bit-serial divider, multiplies and
// presents the output; misses skip the divider and multiply, markers the walk too.
// Front and back overlap through a two-entry queue. Reset is synchronous,
// active low, and restores the register defaults.
// A stalled result holds the back end; the front keeps filling the queue until it is full.
module angular_collimator_weight_core #(
    parameter int MAX_CENTERS = 64,
    parameter int CORDIC_STEPS = 16,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // vel_x, vel_y, weight, zero fill
    input  logic        s_axis_tlast,  // end_marker
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // weight_out
    output logic [1:0]  m_axis_tuser,  // status
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_wdata
);
    import acw_pkg::*;

    logic               mode_reg;
    logic [6:0]         count_reg;
    logic [16:0]        peak_reg;
    logic [15:0]        hw_reg;
    logic signed [16:0] space_reg, first_reg;

    // Hold configuration; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0; count_reg <= 7'd1; peak_reg <= 17'd65536;
            hw_reg <= '0; space_reg <= '0; first_reg <= '0;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                REG_MODE:  mode_reg <= cfg_wdata[0];
                REG_COUNT: count_reg <= cfg_wdata[6:0];
                REG_PEAK:  peak_reg <= cfg_wdata;
                REG_HW:    hw_reg <= cfg_wdata[15:0];
                REG_SPACE: space_reg <= cfg_wdata;
                REG_FIRST: first_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic  f_valid, f_ready, b_valid, b_ready;
    item_t f_item, b_item;

    acw_front #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_front (
        .aclk, .aresetn,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .vel_x(s_axis_tdata[17:0]), .vel_y(s_axis_tdata[35:18]),
        .weight(s_axis_tdata[67:36]), .end_marker(s_axis_tlast),
        .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
    );

    acw_queue u_queue (
        .aclk, .aresetn,
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item)
    );

    acw_back #(.MAX_CENTERS(MAX_CENTERS)) u_back (
        .aclk, .aresetn,
        .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
        .angular_mode(mode_reg), .center_count(count_reg),
        .peak_transmission(peak_reg), .half_width(hw_reg),
        .center_spacing(space_reg), .first_center(first_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_status(m_axis_tuser), .out_weight(m_axis_tdata)
    );
endmodule
